/* rtl/pidts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pidts_pkg - shared types and constants
// Command/status types between controller and datapath, widths and helpers
// for the timestamped PID controller.
// ----------------------------------------------------------------------------
package pidts_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned ACC_W     = 48;   // integral and term width
    localparam int unsigned SUM_W     = 50;   // sum of three terms
    localparam int unsigned MUL_W     = 33;   // multiplier operand width
    localparam int unsigned PROD_W    = 2 * MUL_W;
    localparam int unsigned TACC_W    = 80;   // full gain * value product
    localparam int unsigned DIV_W     = 63;   // divider numerator width
    localparam int unsigned DER_NUM_W = 42;   // |delta error| * 1000
    localparam int unsigned CNT_W     = 6;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned MS_PER_S  = 1000;

    // divide by 1000: 16-bit digits, partial dividend below 2^26,
    // quotient digit = (y * ceil(2^36 / 1000)) >> 36, exact for y < 2^26
    localparam int unsigned KDIV_DIG_W = 16;
    localparam int unsigned KDIV_REM_W = 10;
    localparam int unsigned KDIV_Y_W   = KDIV_REM_W + KDIV_DIG_W;
    localparam int unsigned KDIV_SHIFT = 36;
    localparam logic [26:0] KDIV_RECIP = 27'd68719477;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P       = 2'd0,
        CFG_GAIN_I       = 2'd1,
        CFG_GAIN_D       = 2'd2,
        CFG_OUTPUT_LIMIT = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOAD      = 4'd1,
        OP_MUL_INC   = 4'd2,
        OP_DER_ZERO  = 4'd3,
        OP_DIV_INC   = 4'd4,
        OP_INT_UPD   = 4'd5,
        OP_DER_UPD   = 4'd6,
        OP_MUL_HI    = 4'd7,
        OP_MUL_LO    = 4'd8,
        OP_TERM_ACC  = 4'd9,
        OP_FINISH    = 4'd10
    } t_dp_op;

    typedef enum logic [1:0] {
        TERM_P = 2'd0,
        TERM_I = 2'd1,
        TERM_D = 2'd2
    } t_term;

    typedef struct packed {
        t_dp_op op;
        t_term  term;
    } t_dp_cmd;

    typedef struct packed {
        logic dtm_zero;
        logic inc_done;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_dp_stat;

    // saturate a 64 bit signed value to the signed 48 bit range
    function automatic logic signed [ACC_W-1:0] sat48(input logic signed [63:0] v);
        logic all_same;
        all_same = (&v[63:ACC_W-1]) | ~(|v[63:ACC_W-1]);
        if (all_same) begin
            sat48 = v[ACC_W-1:0];
        end else if (v[63]) begin
            sat48 = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            sat48 = {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

endpackage : pidts_pkg
`default_nettype wire

/* rtl/pidts_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pidts_in_if - sample channel
// Valid/ready channel carrying target, measured value and timestamp.
// ----------------------------------------------------------------------------
interface pidts_in_if
    import pidts_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] measured;
    logic        [DATA_W-1:0] time_ms;

    modport source (output valid, output target, output measured, output time_ms,
                    input ready);
    modport sink   (input valid, input target, input measured, input time_ms,
                    output ready);
endinterface : pidts_in_if
`default_nettype wire

/* rtl/pidts_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pidts_out_if - result channel
// Valid/ready channel carrying drive, error value and clamp flag.
// ----------------------------------------------------------------------------
interface pidts_out_if
    import pidts_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] error_value;
    logic                     clamped;

    modport source (output valid, output drive, output error_value, output clamped,
                    input ready);
    modport sink   (input valid, input drive, input error_value, input clamped,
                    output ready);
endinterface : pidts_out_if
`default_nettype wire

/* rtl/pidts_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pidts_div - serial unsigned divider
// Restoring divider, one quotient bit per cycle. The numerator is loaded
// left-aligned so that a run of i_steps shift-subtract steps leaves the
// quotient in the low i_steps bits.
// ----------------------------------------------------------------------------
module pidts_div
    import pidts_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_W-1:0]  i_num,
    input  wire logic [DATA_W-1:0] i_den,
    input  wire logic [CNT_W-1:0]  i_steps,
    output      logic [DIV_W-1:0]  o_quot,
    output      logic              o_busy,
    output      logic              o_done
);

    logic [DIV_W-1:0]  r_nq;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DATA_W:0]   w_shift;
    logic              w_ge;
    logic [DATA_W:0]   w_sub;

    assign w_shift = {r_rem, r_nq[DIV_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_sub   = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_nq  <= {r_nq[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[DATA_W-1:0] : w_shift[DATA_W-1:0];
        end
    end

    assign o_quot = r_nq;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule : pidts_div
`default_nettype wire

/* rtl/pidts_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pidts_dp - PID datapath
// Configuration registers, controller state, a shared 33x33 multiplier,
// a digit-wise divide by 1000, the serial divider, term accumulation,
// output clamp and result register.
// ----------------------------------------------------------------------------
module pidts_dp
    import pidts_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    output      t_dp_stat                 o_stat,
    input  wire logic signed [DATA_W-1:0] i_target,
    input  wire logic signed [DATA_W-1:0] i_measured,
    input  wire logic        [DATA_W-1:0] i_time_ms,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [DATA_W-1:0]        i_cfg_data,
    output      logic                     o_out_valid,
    input  wire logic                     i_out_ready,
    output      logic signed [DATA_W-1:0] o_drive,
    output      logic signed [DATA_W-1:0] o_error_value,
    output      logic                     o_clamped
);

    // configuration
    logic signed [DATA_W-1:0] r_gain_p;
    logic signed [DATA_W-1:0] r_gain_i;
    logic signed [DATA_W-1:0] r_gain_d;
    logic        [DATA_W-2:0] r_limit;

    // controller state
    logic signed [ACC_W-1:0]  r_integral;
    logic signed [DATA_W-1:0] r_last_err;
    logic        [DATA_W-1:0] r_last_time;

    // per-sample working registers
    logic signed [DATA_W-1:0] r_e;
    logic        [DATA_W-1:0] r_dtm;
    logic signed [DATA_W:0]   r_diff;
    logic signed [ACC_W-1:0]  r_der;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [TACC_W-1:0] r_tacc;
    logic signed [SUM_W-1:0]  r_sum;

    // divide by 1000
    logic [63:0]              r_k_x;
    logic [KDIV_REM_W-1:0]    r_k_rem;
    logic [KDIV_DIG_W-1:0]    r_k_q;
    logic [2:0]               r_k_cnt;
    logic                     r_k_busy;
    logic                     r_k_done;

    // result register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_drive;
    logic signed [DATA_W-1:0] r_err_out;
    logic                     r_clamped;

    logic signed [DATA_W:0]   w_raw_diff;
    logic signed [DATA_W-1:0] w_e;
    logic signed [DATA_W:0]   w_de;
    logic signed [DATA_W-1:0] w_gain;
    logic signed [ACC_W-1:0]  w_val;
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_mul;
    logic        [PROD_W-1:0] w_prod_mag;
    logic        [DATA_W:0]   w_dmag;
    logic        [DER_NUM_W-1:0] w_dnum;
    logic        [KDIV_Y_W-1:0] w_k_y;
    logic        [52:0]       w_k_mul;
    logic        [KDIV_Y_W-1:0] w_k_qk;
    logic        [KDIV_Y_W-1:0] w_k_rem;
    logic                     w_div_start;
    logic        [DIV_W-1:0]  w_div_num;
    logic        [DATA_W-1:0] w_div_den;
    logic        [CNT_W-1:0]  w_div_steps;
    logic        [DIV_W-1:0]  w_quot;
    logic                     w_div_busy;
    logic                     w_div_done;
    logic signed [55:0]       w_q_inc;
    logic signed [55:0]       w_inc;
    logic signed [55:0]       w_int_sum;
    logic signed [ACC_W-1:0]  w_q_der;
    logic signed [TACC_W-1:0] w_full;
    logic signed [ACC_W-1:0]  w_term;
    logic signed [SUM_W-1:0]  w_lim;
    logic signed [DATA_W-1:0] w_drive;
    logic                     w_hit;
    logic                     w_out_free;

    // error, saturated to 32 bits
    assign w_raw_diff = {i_target[DATA_W-1], i_target} - {i_measured[DATA_W-1], i_measured};
    always_comb begin
        if (w_raw_diff[DATA_W] != w_raw_diff[DATA_W-1]) begin
            w_e = w_raw_diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                     : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            w_e = w_raw_diff[DATA_W-1:0];
        end
    end
    assign w_de = {w_e[DATA_W-1], w_e} - {r_last_err[DATA_W-1], r_last_err};

    // operand selection for the shared multiplier
    always_comb begin
        case (i_cmd.term)
            TERM_P: begin
                w_gain = r_gain_p;
                w_val  = {{(ACC_W-DATA_W){r_e[DATA_W-1]}}, r_e};
            end
            TERM_I: begin
                w_gain = r_gain_i;
                w_val  = r_integral;
            end
            TERM_D: begin
                w_gain = r_gain_d;
                w_val  = r_der;
            end
            default: begin
                w_gain = '0;
                w_val  = '0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.op)
            OP_MUL_INC: begin
                w_mul_a = {r_e[DATA_W-1], r_e};
                w_mul_b = {1'b0, r_dtm};
            end
            OP_MUL_HI: begin
                w_mul_a = {w_gain[DATA_W-1], w_gain};
                w_mul_b = {w_val[ACC_W-1], w_val[ACC_W-1:FRAC_BITS]};
            end
            OP_MUL_LO: begin
                w_mul_a = {w_gain[DATA_W-1], w_gain};
                w_mul_b = {{(MUL_W-FRAC_BITS){1'b0}}, w_val[FRAC_BITS-1:0]};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_mul = w_mul_a * w_mul_b;

    // |e*dtm| / 1000 for the integral, |de|*1000/dtm for the derivative
    assign w_prod_mag = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign w_dmag     = r_diff[DATA_W] ? (DATA_W+1)'(-r_diff) : (DATA_W+1)'(r_diff);
    // times 1000 as 1024 - 16 - 8
    assign w_dnum = (DER_NUM_W'(w_dmag) << 10) - (DER_NUM_W'(w_dmag) << 4)
                  - (DER_NUM_W'(w_dmag) << 3);

    // long division by 1000, one 16-bit digit at a time:
    // odd count forms the digit quotient, even count takes the remainder
    assign w_k_y   = {r_k_rem, r_k_x[63:48]};
    assign w_k_mul = {27'd0, w_k_y} * {26'd0, KDIV_RECIP};
    assign w_k_qk  = KDIV_Y_W'(r_k_q * MS_PER_S);
    assign w_k_rem = w_k_y - w_k_qk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_busy <= 1'b0;
            r_k_done <= 1'b0;
            r_k_cnt  <= '0;
        end else begin
            r_k_done <= 1'b0;
            if (i_cmd.op == OP_DIV_INC) begin
                r_k_busy <= 1'b1;
                r_k_cnt  <= 3'd7;
            end else if (r_k_busy) begin
                r_k_cnt <= r_k_cnt - 1'b1;
                if (r_k_cnt == 3'd0) begin
                    r_k_busy <= 1'b0;
                    r_k_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_DIV_INC) begin
            r_k_x   <= {1'b0, w_prod_mag[DIV_W-1:0]};
            r_k_rem <= '0;
        end else if (r_k_busy) begin
            if (r_k_cnt[0]) begin
                r_k_q <= w_k_mul[KDIV_SHIFT+KDIV_DIG_W-1:KDIV_SHIFT];
            end else begin
                r_k_rem <= w_k_rem[KDIV_REM_W-1:0];
                r_k_x   <= {r_k_x[63-KDIV_DIG_W:0], r_k_q};
            end
        end
    end

    assign w_div_start = (i_cmd.op == OP_INT_UPD);
    assign w_div_num   = {w_dnum, {(DIV_W-DER_NUM_W){1'b0}}};
    assign w_div_den   = r_dtm;
    assign w_div_steps = CNT_W'(DER_NUM_W);

    pidts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_steps (w_div_steps),
        .o_quot  (w_quot),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done)
    );

    // signed quotients
    assign w_q_inc   = {1'b0, r_k_x[54:0]};
    assign w_inc     = r_prod[PROD_W-1] ? -w_q_inc : w_q_inc;
    assign w_int_sum = {{(56-ACC_W){r_integral[ACC_W-1]}}, r_integral} + w_inc;
    assign w_q_der   = {{(ACC_W-DER_NUM_W){1'b0}}, w_quot[DER_NUM_W-1:0]};

    // term = floor(gain * value / 2^16), saturated to 48 bits
    assign w_full = r_tacc + {{(TACC_W-64){r_prod[63]}}, r_prod[63:0]};
    assign w_term = sat48(w_full[TACC_W-1:FRAC_BITS]);

    // clamp
    assign w_lim = {{(SUM_W-DATA_W+1){1'b0}}, r_limit};
    always_comb begin
        if (r_sum < -w_lim) begin
            w_drive = DATA_W'(-w_lim);
            w_hit   = 1'b1;
        end else if (r_sum > w_lim) begin
            w_drive = DATA_W'(w_lim);
            w_hit   = 1'b1;
        end else begin
            w_drive = r_sum[DATA_W-1:0];
            w_hit   = 1'b0;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= DATA_W'(65536);
            r_gain_i <= '0;
            r_gain_d <= DATA_W'(72);
            r_limit  <= (DATA_W-1)'(3276800);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_P:       r_gain_p <= i_cfg_data;
                CFG_GAIN_I:       r_gain_i <= i_cfg_data;
                CFG_GAIN_D:       r_gain_d <= i_cfg_data;
                CFG_OUTPUT_LIMIT: r_limit  <= i_cfg_data[DATA_W-2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral  <= '0;
            r_last_err  <= '0;
            r_last_time <= '0;
        end else begin
            if (i_cmd.op == OP_LOAD) begin
                r_last_err  <= w_e;
                r_last_time <= i_time_ms;
            end
            if (i_cmd.op == OP_INT_UPD) begin
                r_integral <= sat48(64'(w_int_sum));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_e    <= w_e;
                r_dtm  <= i_time_ms - r_last_time;
                r_diff <= w_de;
                r_sum  <= '0;
            end
            OP_MUL_INC: r_prod <= w_mul;
            OP_DER_ZERO: r_der <= '0;
            OP_DER_UPD: r_der <= r_diff[DATA_W] ? -w_q_der : w_q_der;
            OP_MUL_HI: r_prod <= w_mul;
            OP_MUL_LO: begin
                r_tacc <= {r_prod[63:0], {FRAC_BITS{1'b0}}};
                r_prod <= w_mul;
            end
            OP_TERM_ACC: r_sum <= r_sum + {{(SUM_W-ACC_W){w_term[ACC_W-1]}}, w_term};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FINISH) begin
            r_drive   <= w_drive;
            r_err_out <= r_e;
            r_clamped <= w_hit;
        end
    end

    assign o_stat.dtm_zero = (r_dtm == '0);
    assign o_stat.inc_done = r_k_done;
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = w_out_free;

    assign o_out_valid   = r_out_valid;
    assign o_drive       = r_drive;
    assign o_error_value = r_err_out;
    assign o_clamped     = r_clamped;

endmodule : pidts_dp
`default_nettype wire

/* rtl/pidts_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pidts_ctrl - PID sequencer
// One-hot state machine that steps the datapath through load, integral
// division, derivative division (both skipped for a zero time step), three gain terms and the output write.
// ----------------------------------------------------------------------------
module pidts_ctrl
    import pidts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output      logic     o_in_ready,
    output      t_dp_cmd  o_cmd,
    input  wire t_dp_stat i_stat
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_MUL_INC  = 11'b000_0000_0010,
        S_DIV_GO   = 11'b000_0000_0100,
        S_DIV_INC  = 11'b000_0000_1000,
        S_INT_UPD  = 11'b000_0001_0000,
        S_DIV_DER  = 11'b000_0010_0000,
        S_DER_UPD  = 11'b000_0100_0000,
        S_MUL_HI   = 11'b000_1000_0000,
        S_MUL_LO   = 11'b001_0000_0000,
        S_TERM_ACC = 11'b010_0000_0000,
        S_FINISH   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_term  r_term;
    t_term  n_term;

    always_comb begin
        n_state    = r_state;
        n_term     = r_term;
        o_cmd.op   = OP_NONE;
        o_cmd.term = r_term;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_term   = TERM_P;
                    n_state  = S_MUL_INC;
                end
            end
            S_MUL_INC: begin
                // zero time step: integral holds, derivative is zero
                if (i_stat.dtm_zero) begin
                    o_cmd.op = OP_DER_ZERO;
                    n_state  = S_MUL_HI;
                end else begin
                    o_cmd.op = OP_MUL_INC;
                    n_state  = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                o_cmd.op = OP_DIV_INC;
                n_state  = S_DIV_INC;
            end
            S_DIV_INC: begin
                if (i_stat.inc_done) begin
                    n_state = S_INT_UPD;
                end
            end
            S_INT_UPD: begin
                // update the integral and launch the derivative division
                o_cmd.op = OP_INT_UPD;
                n_state  = S_DIV_DER;
            end
            S_DIV_DER: begin
                if (i_stat.div_done) begin
                    n_state = S_DER_UPD;
                end
            end
            S_DER_UPD: begin
                o_cmd.op = OP_DER_UPD;
                n_state  = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.op = OP_MUL_HI;
                n_state  = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.op = OP_MUL_LO;
                n_state  = S_TERM_ACC;
            end
            S_TERM_ACC: begin
                o_cmd.op = OP_TERM_ACC;
                case (r_term)
                    TERM_P: begin
                        n_term  = TERM_I;
                        n_state = S_MUL_HI;
                    end
                    TERM_I: begin
                        n_term  = TERM_D;
                        n_state = S_MUL_HI;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_FINISH: begin
                // hold until the result register can take the transaction
                if (i_stat.out_free) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_term  <= TERM_P;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
        end
    end

endmodule : pidts_ctrl
`default_nettype wire

/* rtl/pid_controller_timestamped_top.sv */
`default_nettype none
// Sequence: a digit-wise divide by 1000 for the integral step, a 42-step serial
// divide for the derivative (both skipped for a zero time step), then three
// two-pass gain multiplies.
// Flow: a new sample is taken only once the last one is through; a result that
// the sink holds off stalls the final write and with it the next sample.
// Reset: synchronous active-low; clears integral, last error, last timestamp.
// ----------------------------------------------------------------------------
// pid_controller_timestamped_top - timestamped PID controller with clamp
// Signed Q16.16 PID with saturating integral, derivative over the measured
// time step and a symmetric output limit.
// ----------------------------------------------------------------------------
module pid_controller_timestamped_top
    import pidts_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    pidts_in_if.sink                  i_in,
    pidts_out_if.source               o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DATA_W-1:0]    i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    pidts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    pidts_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_target      (i_in.target),
        .i_measured    (i_in.measured),
        .i_time_ms     (i_in.time_ms),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_drive       (o_out.drive),
        .o_error_value (o_out.error_value),
        .o_clamped     (o_out.clamped)
    );

    assign i_in.ready = w_in_ready;

`ifndef SYNTHESIS
    a_one_per_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken twice for one item");

    a_finish_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_FINISH) |-> w_stat.out_free)
        else $error("result written over a pending transaction");

    a_div_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_INT_UPD) |-> !w_stat.div_busy)
        else $error("divider started while busy");

    a_out_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.op == OP_FINISH))
        else $error("result valid without a finish");
`endif

endmodule : pid_controller_timestamped_top
`default_nettype wire

/* tb/pid_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_result_checker - result predictor and comparator for the PID block
// Watches the sample, result and register channels. It keeps its own copy of
// the gains, the limit, the integral, the last error and the last timestamp.
// For every accepted sample it queues the drive it expects, then compares each
// accepted result with the oldest entry, field by field.
// ----------------------------------------------------------------------------
module pid_result_checker
    import pidts_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    pidts_in_if                       i_smp,
    pidts_out_if                      i_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DATA_W-1:0]    i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam longint ACC_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN    = -ACC_MAX - 1;
    localparam longint ERR_MAX    = 64'sh0000_0000_7FFF_FFFF;
    localparam longint ERR_MIN    = -ERR_MAX - 1;
    localparam longint MS_PER_SEC = 1000;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic signed [DATA_W-1:0] error_value;
        logic                     clamped;
    } pid_result_t;

    pid_result_t expected_drives[$];

    longint      gain_p;
    longint      gain_i;
    longint      gain_d;
    longint      drive_limit;
    longint      integral;
    longint      prev_error;
    logic [31:0] prev_ms;
    int          fails;
    int          result_cnt;

    initial begin
        fails      = 0;
        result_cnt = 0;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // floor(gain * value / 2^16), held to the 48 bit term range
    function automatic longint gain_mul(input longint gain, input longint value);
        logic signed [95:0] g_w;
        logic signed [95:0] v_w;
        logic signed [95:0] prod;
        g_w  = gain;
        v_w  = value;
        prod = (g_w * v_w) >>> FRAC_BITS;
        if (prod > ACC_MAX) begin
            return ACC_MAX;
        end else if (prod < ACC_MIN) begin
            return ACC_MIN;
        end
        return prod[63:0];
    endfunction

    // work out one control step and advance the controller state
    function automatic pid_result_t predict_drive(input logic signed [DATA_W-1:0] tgt,
                                                  input logic signed [DATA_W-1:0] meas,
                                                  input logic [DATA_W-1:0] now);
        pid_result_t res;
        longint      t_l;
        longint      m_l;
        longint      err;
        longint      dt_l;
        longint      der;
        longint      total;
        longint      drv;
        logic [31:0] dtm;
        t_l   = tgt;
        m_l   = meas;
        err   = clip(t_l - m_l, ERR_MIN, ERR_MAX);
        dtm   = now - prev_ms;
        dt_l  = {32'd0, dtm};
        der   = 0;
        // a zero step leaves the integral alone and gives no derivative
        if (dtm != 0) begin
            integral = clip(integral + (err * dt_l) / MS_PER_SEC, ACC_MIN, ACC_MAX);
            der      = ((err - prev_error) * MS_PER_SEC) / dt_l;
        end
        total = gain_mul(gain_p, err) + gain_mul(gain_i, integral) + gain_mul(gain_d, der);
        drv         = total;
        res.clamped = 1'b0;
        if (total < -drive_limit) begin
            drv         = -drive_limit;
            res.clamped = 1'b1;
        end else if (total > drive_limit) begin
            drv         = drive_limit;
            res.clamped = 1'b1;
        end
        res.drive       = drv[31:0];
        res.error_value = err[31:0];
        prev_error      = err;
        prev_ms         = now;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: result %0d: %s", $time, result_cnt, msg);
        fails++;
    endtask

    always @(posedge i_clk) begin : watch
        pid_result_t        want;
        logic signed [31:0] cfg_s;
        if (!i_rst_n) begin
            gain_p      = 65536;
            gain_i      = 0;
            gain_d      = 72;
            drive_limit = 3276800;
            integral    = 0;
            prev_error  = 0;
            prev_ms     = '0;
            expected_drives.delete();
        end else begin
            if (i_cfg_we) begin
                cfg_s = i_cfg_data;
                case (i_cfg_idx)
                    CFG_GAIN_P:       gain_p      = cfg_s;
                    CFG_GAIN_I:       gain_i      = cfg_s;
                    CFG_GAIN_D:       gain_d      = cfg_s;
                    CFG_OUTPUT_LIMIT: drive_limit = {33'd0, i_cfg_data[30:0]};
                    default: ;
                endcase
            end
            // retire the result first: it cannot belong to a sample taken this edge
            if (i_res.valid && i_res.ready) begin
                if (expected_drives.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want = expected_drives.pop_front();
                    if (i_res.drive !== want.drive) begin
                        report_mismatch($sformatf("drive %08h, expected %08h",
                                                  i_res.drive, want.drive));
                    end
                    if (i_res.error_value !== want.error_value) begin
                        report_mismatch($sformatf("error_value %08h, expected %08h",
                                                  i_res.error_value, want.error_value));
                    end
                    if (i_res.clamped !== want.clamped) begin
                        report_mismatch($sformatf("clamped %b, expected %b",
                                                  i_res.clamped, want.clamped));
                    end
                end
                result_cnt++;
            end
            if (i_smp.valid && i_smp.ready) begin
                expected_drives.push_back(predict_drive(i_smp.target, i_smp.measured,
                                                        i_smp.time_ms));
            end
        end
        o_pending    <= expected_drives.size();
        o_fail_count <= fails;
    end

endmodule : pid_result_checker

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the timestamped PID controller
// Drives samples with random gaps and random result back-pressure, rewrites
// gains and limit between phases while the block is idle, and leaves the
// checking to pid_result_checker. Directed samples cover the first step,
// zero steps, timestamp wrap, error overflow and a zero limit; random phases
// mix tracking sequences, wind-up runs and full-range noise.
// ----------------------------------------------------------------------------
module tb_top;
    import pidts_pkg::*;

    localparam int SETTLE_CYCLES = 150;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 118;
    localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0]    cfg_data;
    logic                 ready_free;
    logic                 no_gaps;
    logic [31:0]          clock_ms;
    int                   ready_hold;
    int                   fail_count;
    int                   pending;

    pidts_in_if  smp_ch ();
    pidts_out_if res_ch ();

    pid_controller_timestamped_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (smp_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pid_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_smp        (smp_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #15_000_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 200);
    endfunction

    // result back-pressure: runs of ready, stalls mostly short, a few long
    always @(posedge clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (ready_free) begin
            res_ch.ready <= 1'b1;
        end else if ($urandom_range(0, 2) != 0) begin
            res_ch.ready <= 1'b1;
            ready_hold = $urandom_range(0, 15);
        end else begin
            res_ch.ready <= 1'b0;
            ready_hold = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2) :
                         ($urandom_range(0, 99) < 85) ? $urandom_range(3, 12) :
                                                        $urandom_range(40, 150);
        end
    end

    task automatic send_sample(input logic signed [31:0] tgt, input logic signed [31:0] meas,
                               input logic [31:0] tms);
        int gap;
        smp_ch.valid    <= 1'b1;
        smp_ch.target   <= tgt;
        smp_ch.measured <= meas;
        smp_ch.time_ms  <= tms;
        @(posedge clk);
        while (!smp_ch.ready) @(posedge clk);
        gap = idle_len();
        if (gap > 0) begin
            smp_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until every result is back, then let the block settle
    task automatic wait_idle();
        smp_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input logic [31:0] kp, input logic [31:0] ki,
                               input logic [31:0] kd, input logic [31:0] lim);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_GAIN_P;
        cfg_data <= kp;
        @(posedge clk);
        cfg_idx  <= CFG_GAIN_I;
        cfg_data <= ki;
        @(posedge clk);
        cfg_idx  <= CFG_GAIN_D;
        cfg_data <= kd;
        @(posedge clk);
        cfg_idx  <= CFG_OUTPUT_LIMIT;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] pick_gain();
        int r;
        int v;
        r = $urandom_range(0, 9);
        case (r)
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'd0;
            3, 4: return $urandom();
            default: begin
                v = $urandom_range(0, 1048576);
                return v - 524288;
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom();
            default: return $urandom_range(0, 200 * 65536);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_level();
        int v;
        v = $urandom_range(0, 400 * 65536);
        return v - 200 * 65536;
    endfunction

    function automatic logic signed [31:0] pick_edge();
        case ($urandom_range(0, 3))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'sd0;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random_sample();
        int                 r;
        int                 noise;
        logic signed [31:0] tgt;
        logic signed [31:0] meas;
        logic [31:0]        dt;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            // tracking: measurement close to the target, short steps
            tgt   = pick_level();
            noise = $urandom_range(0, 16 * 65536);
            meas  = tgt + noise - 8 * 65536;
            dt    = $urandom_range(1, 100);
        end else if (r < 65) begin
            tgt  = pick_level();
            meas = pick_level();
            dt   = 0;
        end else if (r < 75) begin
            tgt  = $urandom();
            meas = $urandom();
            dt   = $urandom();
        end else if (r < 82) begin
            tgt  = pick_edge();
            meas = pick_edge();
            dt   = $urandom_range(0, 3);
        end else if (r < 92) begin
            // wind-up: saturated error over a long step
            tgt  = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            meas = ~tgt;
            dt   = $urandom_range(32'h4000_0000, 32'hFFFF_FFFF);
        end else begin
            tgt  = pick_level();
            meas = pick_level();
            dt   = $urandom_range(1, 60000);
        end
        clock_ms = clock_ms + dt;
        send_sample(tgt, meas, clock_ms);
    endtask

    initial begin
        logic [31:0] kp;
        logic [31:0] ki;
        logic [31:0] kd;
        logic [31:0] lim;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_GAIN_P;
        cfg_data        = '0;
        smp_ch.valid    = 1'b0;
        smp_ch.target   = '0;
        smp_ch.measured = '0;
        smp_ch.time_ms  = '0;
        res_ch.ready    = 1'b0;
        ready_free      = 1'b0;
        no_gaps         = 1'b0;
        ready_hold      = 0;
        clock_ms        = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains and limit: first step, zero steps, overflow, wrap, clamps
        send_sample(Q_ONE, 32'sd0, 32'd10);
        send_sample(2 * Q_ONE, 32'sd0, 32'd10);
        send_sample(32'sh0000_8000, 32'sh0000_4000, 32'd25);
        send_sample(100 * Q_ONE, 32'sd0, 32'd35);
        send_sample(-100 * Q_ONE, 32'sd0, 32'd45);
        send_sample(Q_MAX, Q_MIN, 32'd50);
        send_sample(Q_MIN, Q_MAX, 32'd51);
        send_sample(Q_MIN, Q_MAX, 32'd51);
        send_sample(Q_MAX, 32'sd0, 32'hFFFF_FFF0);
        send_sample(Q_MIN, 32'sd0, 32'h0000_0010);
        send_sample(32'sd0, 32'sd0, 32'hFFFF_FFFF);
        send_sample(32'sd0, Q_MAX, 32'd0);
        send_sample(32'sd0, 32'sd0, 32'd0);
        wait_idle();

        // zero limit
        load_config(2 * Q_ONE, Q_ONE, 32'h0000_8000, 32'd0);
        send_sample(Q_ONE, 32'sd0, 32'd5);
        send_sample(32'sd0, 32'sd0, 32'd5);
        send_sample(-3 * Q_ONE, 32'sd0, 32'd1005);
        send_sample(32'sd0, 32'sd0, 32'd2005);
        wait_idle();

        // extreme gains, widest limit
        load_config(Q_MAX, Q_MIN, Q_MAX, 32'h7FFF_FFFF);
        send_sample(Q_MAX, Q_MIN, 32'h4000_0000);
        send_sample(Q_MIN, Q_MAX, 32'h4000_0001);
        send_sample(Q_MAX, Q_MIN, 32'hC000_0000);
        send_sample(32'sd1, 32'sd0, 32'hC000_0000);
        wait_idle();
        clock_ms = 32'hC000_0000;

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    kp = Q_ONE; ki = 32'h0000_8000; kd = 32'h0000_028F; lim = 100 * Q_ONE;
                end
                1: begin
                    kp = Q_MAX; ki = Q_MAX; kd = Q_MAX; lim = 32'h7FFF_FFFF;
                end
                2: begin
                    kp = Q_MIN; ki = Q_MIN; kd = Q_MIN; lim = 32'd0;
                end
                3: begin
                    kp = -2 * Q_ONE; ki = -Q_ONE; kd = 32'hFFFF_F000; lim = 32'hFFFF_FFFF;
                end
                default: begin
                    kp = pick_gain(); ki = pick_gain(); kd = pick_gain(); lim = pick_limit();
                end
            endcase
            ready_free <= (phase % 3 == 2);
            no_gaps = (phase % 4 == 3);
            load_config(kp, ki, kd, lim);
            repeat (PHASE_ITEMS) send_random_sample();
            wait_idle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule : tb_top
